@@ sv/msm_pkg.sv @@
// Shared types, constants and state codes of the multichannel sample mixer.
package msm_pkg;

   // Number of voice channels.
   localparam int CHANNELS = 5;
   // Sample memory depth in bytes; must be a power of two so an address
   // reduces to its low bits.
   localparam int SAMPLE_MEM_DEPTH = 65536;

   localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_ADDR_W = $clog2(SAMPLE_MEM_DEPTH);

   // Request codes.
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_PLAY     = 3'd1;
   localparam logic [2:0] REQ_STOP     = 3'd2;
   localparam logic [2:0] REQ_STOP_ALL = 3'd3;
   localparam logic [2:0] REQ_WRITE    = 3'd4;

   // Recentring bias of an unsigned sample and the saturation limits.
   localparam logic [7:0]         SAMPLE_BIAS = 8'h80;
   localparam logic signed [15:0] SAT_MAX     = 16'sh7FFF;
   localparam logic signed [15:0] SAT_MIN     = 16'sh8000;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [7:0]        sound_id;
      logic [15:0]       address;
      logic [15:0]       length;
      logic signed [7:0] loop_count;
      logic [7:0]        sample_byte;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic               any_active;
   } rsp_word_type;

   // One entry of the channel state memory.
   typedef struct packed {
      logic [7:0]  sound;
      logic [15:0] start;
      logic [15:0] total;
      logic [15:0] pos;
      logic [15:0] remaining;
      logic [7:0]  loops;
   } chan_entry_type;

   // Finished tick result handed from the sequencer to the output register.
   typedef struct packed {
      logic         push;
      rsp_word_type word;
   } msm_result_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_READ,
      CTL_CHAN,
      CTL_SAMPLE,
      CTL_DONE
   } ctl_state_type;

endpackage

@@ sv/msm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module msm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/msm_ctrl.sv @@
// Request sequencer: walks the channel state memory and reads the sample memory.
module msm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msm_pkg::req_word_type req_data,
   input  logic                  out_free,
   output msm_pkg::msm_result_type result
);

   msm_pkg::ctl_state_type state_ff, state_in;
   logic [msm_pkg::CH_W-1:0] ch_ff, ch_in, ch_next;
   msm_pkg::req_word_type    req_ff, req_in;
   logic signed [15:0]       acc_ff, acc_in;
   logic                     any_ff, any_in;
   logic [msm_pkg::CHANNELS-1:0] chan_valid_ff;
   logic                     last_ch;
   logic                     advance;

   logic                                chan_we, chan_re;
   logic [msm_pkg::CH_W-1:0]            chan_raddr;
   logic [$bits(msm_pkg::chan_entry_type)-1:0] chan_rdata;
   msm_pkg::chan_entry_type             chan_cur, chan_wdata, chan_upd;

   logic                                sample_we, sample_re;
   logic [7:0]                          sample_rdata;

   logic signed [7:0]  centered;
   logic signed [15:0] contrib;
   logic signed [16:0] sum;
   logic signed [15:0] sat_sum;
   logic               cur_active;
   logic [15:0]        rem_dec;
   logic [7:0]         loops_dec;

   // Channel state memory; an entry never written since reset reads as zero.
   msm_ram #(
      .WIDTH($bits(msm_pkg::chan_entry_type)),
      .DEPTH(msm_pkg::CHANNELS)
   ) u_chan_ram (
      .clock(clock),
      .we   (chan_we),
      .waddr(ch_ff),
      .wdata(chan_wdata),
      .re   (chan_re),
      .raddr(chan_raddr),
      .rdata(chan_rdata)
   );

   msm_ram #(
      .WIDTH(8),
      .DEPTH(msm_pkg::SAMPLE_MEM_DEPTH)
   ) u_sample_ram (
      .clock(clock),
      .we   (sample_we),
      .waddr(req_data.address[msm_pkg::SAMPLE_ADDR_W-1:0]),
      .wdata(req_data.sample_byte),
      .re   (sample_re),
      .raddr(chan_cur.pos[msm_pkg::SAMPLE_ADDR_W-1:0]),
      .rdata(sample_rdata)
   );

   assign chan_cur   = chan_valid_ff[ch_ff] ? msm_pkg::chan_entry_type'(chan_rdata) : '0;
   assign cur_active = (chan_cur.sound != 8'd0) && (chan_cur.loops != 8'd0);
   assign ch_next    = ch_ff + msm_pkg::CH_W'(1);
   assign last_ch    = (ch_ff == msm_pkg::CH_W'(msm_pkg::CHANNELS - 1));

   // Mix arithmetic: recentre, scale to 16 bits, saturating add.
   assign centered = $signed(sample_rdata ^ msm_pkg::SAMPLE_BIAS);
   assign contrib  = {centered, 8'h00};
   assign sum      = {acc_ff[15], acc_ff} + {contrib[15], contrib};
   assign sat_sum  = (sum[16] != sum[15]) ? (sum[16] ? msm_pkg::SAT_MIN : msm_pkg::SAT_MAX)
                                          : sum[15:0];

   // Position and loop bookkeeping of the channel that just played a sample.
   assign rem_dec   = (chan_cur.remaining != 16'd0) ? chan_cur.remaining - 16'd1 : 16'd0;
   assign loops_dec = ((chan_cur.loops != 8'd0) && !chan_cur.loops[7]) ?
                      chan_cur.loops - 8'd1 : chan_cur.loops;

   always_comb begin
      chan_upd           = chan_cur;
      chan_upd.pos       = chan_cur.pos + 16'd1;
      chan_upd.remaining = rem_dec;
      if (rem_dec == 16'd0) begin
         chan_upd.loops = loops_dec;
         if ((loops_dec != 8'd0) && (chan_cur.total != 16'd0)) begin
            chan_upd.pos       = chan_cur.start;
            chan_upd.remaining = chan_cur.total;
         end else begin
            chan_upd.sound = 8'd0;
            chan_upd.loops = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msm_pkg::CTL_IDLE;
         chan_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (chan_we) begin
            chan_valid_ff[ch_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      req_ff <= req_in;
      acc_ff <= acc_in;
      any_ff <= any_in;
   end

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      req_in      = req_ff;
      acc_in      = acc_ff;
      any_in      = any_ff;
      req_ready   = 1'b0;
      chan_re     = 1'b0;
      chan_raddr  = ch_ff;
      chan_we     = 1'b0;
      chan_wdata  = chan_cur;
      sample_we   = 1'b0;
      sample_re   = 1'b0;
      advance     = 1'b0;
      result.push = 1'b0;
      result.word.mixed_sample = acc_ff;
      result.word.any_active   = any_ff;

      case (state_ff)
         msm_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && enable) begin
               req_in = req_data;
               ch_in  = '0;
               acc_in = '0;
               any_in = 1'b0;
               case (req_data.req_type)
                  msm_pkg::REQ_TICK,
                  msm_pkg::REQ_STOP_ALL: begin
                     state_in = msm_pkg::CTL_READ;
                  end
                  msm_pkg::REQ_PLAY: begin
                     if ((req_data.sound_id != 8'd0) && (req_data.length != 16'd0)) begin
                        state_in = msm_pkg::CTL_READ;
                     end
                  end
                  msm_pkg::REQ_STOP: begin
                     if (req_data.sound_id != 8'd0) begin
                        state_in = msm_pkg::CTL_READ;
                     end
                  end
                  msm_pkg::REQ_WRITE: begin
                     sample_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         msm_pkg::CTL_READ: begin
            chan_re  = 1'b1;
            state_in = msm_pkg::CTL_CHAN;
         end
         msm_pkg::CTL_CHAN: begin
            case (req_ff.req_type)
               msm_pkg::REQ_TICK: begin
                  if (cur_active) begin
                     sample_re = 1'b1;
                     state_in  = msm_pkg::CTL_SAMPLE;
                  end else begin
                     advance = 1'b1;
                  end
               end
               msm_pkg::REQ_PLAY: begin
                  if ((chan_cur.sound == req_ff.sound_id) || (chan_cur.loops == 8'd0)) begin
                     chan_we              = 1'b1;
                     chan_wdata.sound     = req_ff.sound_id;
                     chan_wdata.start     = req_ff.address;
                     chan_wdata.pos       = req_ff.address;
                     chan_wdata.total     = req_ff.length;
                     chan_wdata.remaining = req_ff.length;
                     chan_wdata.loops     = $unsigned(req_ff.loop_count);
                     state_in             = msm_pkg::CTL_DONE;
                  end else begin
                     advance = 1'b1;
                  end
               end
               msm_pkg::REQ_STOP,
               msm_pkg::REQ_STOP_ALL: begin
                  if (((req_ff.req_type == msm_pkg::REQ_STOP) &&
                       (chan_cur.sound == req_ff.sound_id)) ||
                      ((req_ff.req_type == msm_pkg::REQ_STOP_ALL) &&
                       (chan_cur.sound != 8'd0))) begin
                     chan_we          = 1'b1;
                     chan_wdata.sound = 8'd0;
                     chan_wdata.loops = 8'd0;
                  end
                  advance = 1'b1;
               end
               default: begin
                  state_in = msm_pkg::CTL_DONE;
               end
            endcase
         end
         msm_pkg::CTL_SAMPLE: begin
            chan_we    = 1'b1;
            chan_wdata = chan_upd;
            acc_in     = sat_sum;
            any_in     = 1'b1;
            advance    = 1'b1;
         end
         msm_pkg::CTL_DONE: begin
            if (req_ff.req_type == msm_pkg::REQ_TICK) begin
               if (out_free) begin
                  result.push = 1'b1;
                  state_in    = msm_pkg::CTL_IDLE;
               end
            end else begin
               state_in = msm_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = msm_pkg::CTL_IDLE;
         end
      endcase

      // Step to the next channel, prefetching its entry while this one is
      // written back.
      if (advance) begin
         if (last_ch) begin
            state_in = msm_pkg::CTL_DONE;
         end else begin
            chan_re    = 1'b1;
            chan_raddr = ch_next;
            ch_in      = ch_next;
            state_in   = msm_pkg::CTL_CHAN;
         end
      end
   end

`ifndef SYNTHESIS
   // The prefetch of the next channel never collides with the write-back.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (chan_we && chan_re) |-> (chan_raddr != ch_ff))
      else $error("channel memory read and write hit the same entry");

   // A result is handed over only when the output register can take it.
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      result.push |-> out_free)
      else $error("tick result pushed into a full output register");

   // A sample read is always consumed in the following cycle.
   a_sample_consumed: assert property (@(posedge clock) disable iff (reset)
      sample_re |=> (state_ff == msm_pkg::CTL_SAMPLE))
      else $error("sample read not followed by mixing step");

   // The channel walk stays within the channel set.
   a_ch_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != msm_pkg::CTL_IDLE) |->
      (ch_ff <= msm_pkg::CH_W'(msm_pkg::CHANNELS - 1)))
      else $error("channel index out of range");

   // New requests are taken only while the sequencer is idle.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == msm_pkg::CTL_IDLE))
      else $error("request accepted while a walk is in progress");
`endif

endmodule

@@ sv/multichannel_sample_mixer.sv @@
// Top level of the multichannel sample mixer: control register, sequencer, output register.
//
// The mixer takes request words on the req_ channel (valid/ready) and hands
// mixed audio samples out on the rsp_ channel (valid/ready). A write word
// stores one byte into the sample memory and leaves the mixer idle. Play,
// stop and stop-all words walk the channel state memory one entry per cycle.
// A tick word walks it too, and each active channel adds one sample memory
// read before its entry is written back; the tick's result word lands in
// the output register at the end of that walk. The mixer works on one
// request word at a time.
//
// The output register parts the two sides: the next request word is taken
// while a finished result word still waits for rsp_ready. Only when a
// second tick finishes while the first result is still held does the walk
// pause in its last step until the receiver takes the held word.
//
// Reset clears the enable register, the output register and the channel
// valid flags, so every channel reads as idle at once; no clearing pass is
// needed. The sample memory holds whatever was written. While the enable
// bit is zero every request word is accepted and dropped.
module multichannel_sample_mixer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msm_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output msm_pkg::rsp_word_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   // Mixer enable bit, written through the control port.
   logic enable_ff, enable_in;

   // Output register holding one finished result word.
   logic                  rsp_valid_ff, rsp_valid_in;
   msm_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   msm_pkg::msm_result_type result;
   logic                    out_free;

   // The register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   msm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .out_free (out_free),
      .result   (result)
   );

   always_comb begin
      enable_in    = csr_write_enable ? csr_write_data : enable_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/sv/tb_multichannel_sample_mixer.sv @@
// Self-checking testbench of the multichannel sample mixer: stimulus, mix prediction and checks.
`timescale 1ns / 1ps

module tb_multichannel_sample_mixer;

   // Request codes 5 to 7 have no meaning; the mixer must drop such words quietly.
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

   // All sounds that really play live in one small window of sample memory.
   // The window runs across the top of the address space into address zero,
   // so play positions wrap at 16 bits. Every byte of it is written before
   // the first play, which keeps the mixer from ever reading a byte that
   // was never written.
   localparam logic [15:0] WIN_BASE = 16'hFFF0;
   localparam int          WIN_SIZE = 32;

   // Words without a result may still be in the walk when the last mixed
   // word has arrived, so every pause waits a little longer than a tick walk
   // with every channel active.
   localparam int DRAIN = 3 + 2 * msm_pkg::CHANNELS + 4;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   msm_pkg::req_word_type req_data         = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   msm_pkg::rsp_word_type rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data   = 1'b0;

   // Words waiting to be offered, and mixed words the mixer still owes us.
   msm_pkg::req_word_type word_backlog[$];
   msm_pkg::rsp_word_type mix_due[$];
   msm_pkg::rsp_word_type mix_head;

   // Our own picture of the mixer: the enable bit, the voices and the memory.
   logic       mix_on = 1'b0;
   logic [7:0]  voice_id    [msm_pkg::CHANNELS] = '{default: '0};
   logic [15:0] voice_base  [msm_pkg::CHANNELS] = '{default: '0};
   logic [15:0] voice_total [msm_pkg::CHANNELS] = '{default: '0};
   logic [15:0] voice_ptr   [msm_pkg::CHANNELS] = '{default: '0};
   logic [15:0] voice_left  [msm_pkg::CHANNELS] = '{default: '0};
   logic [7:0]  voice_reps  [msm_pkg::CHANNELS] = '{default: '0};
   logic [7:0]  pcm_mem     [msm_pkg::SAMPLE_MEM_DEPTH];

   // Handshake pacing of both sides and the error tally.
   int send_gap  = 0;
   int send_calm = 0;
   int take_gap  = 0;
   int take_calm = 0;
   int hold_off  = 0;
   int mix_taken = 0;
   int bad_count = 0;

   multichannel_sample_mixer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one accepted request word to the voice state and queues the
   // mixed word that a tick must produce. Channels are walked in order and
   // the running sum clips after every channel, so the order matters once
   // the sum has hit a rail.
   function automatic void mixer_advance(msm_pkg::req_word_type w);
      int                    acc;
      int                    s;
      int                    slot;
      logic                  hit;
      msm_pkg::rsp_word_type r;
      if (!mix_on)
         return;
      case (w.req_type)
         msm_pkg::REQ_TICK: begin
            acc = 0;
            hit = 1'b0;
            for (int c = 0; c < msm_pkg::CHANNELS; c++) begin
               if (voice_id[c] != 8'd0 && voice_reps[c] != 8'd0) begin
                  hit = 1'b1;
                  s = int'(pcm_mem[voice_ptr[c] % msm_pkg::SAMPLE_MEM_DEPTH])
                      - int'(msm_pkg::SAMPLE_BIAS);
                  acc += s * 256;
                  if (acc > int'(msm_pkg::SAT_MAX))
                     acc = int'(msm_pkg::SAT_MAX);
                  else if (acc < int'(msm_pkg::SAT_MIN))
                     acc = int'(msm_pkg::SAT_MIN);
                  voice_ptr[c]++;
                  if (voice_left[c] != 16'd0)
                     voice_left[c]--;
                  if (voice_left[c] == 16'd0) begin
                     // Only a positive count runs down; a negative one loops forever.
                     if (voice_reps[c] != 8'd0 && !voice_reps[c][7])
                        voice_reps[c]--;
                     if (voice_reps[c] != 8'd0 && voice_total[c] != 16'd0) begin
                        voice_ptr[c]  = voice_base[c];
                        voice_left[c] = voice_total[c];
                     end else begin
                        voice_id[c]   = 8'd0;
                        voice_reps[c] = 8'd0;
                     end
                  end
               end
            end
            r.mixed_sample = acc[15:0];
            r.any_active   = hit;
            mix_due.push_back(r);
         end
         msm_pkg::REQ_PLAY: begin
            if (w.sound_id != 8'd0 && w.length != 16'd0) begin
               // The first channel that already holds this sound or is idle wins.
               slot = msm_pkg::CHANNELS;
               for (int c = msm_pkg::CHANNELS - 1; c >= 0; c--)
                  if (voice_id[c] == w.sound_id || voice_reps[c] == 8'd0)
                     slot = c;
               if (slot < msm_pkg::CHANNELS) begin
                  voice_reps[slot]  = w.loop_count;
                  voice_id[slot]    = w.sound_id;
                  voice_base[slot]  = w.address;
                  voice_ptr[slot]   = w.address;
                  voice_total[slot] = w.length;
                  voice_left[slot]  = w.length;
               end
            end
         end
         msm_pkg::REQ_STOP: begin
            if (w.sound_id != 8'd0)
               for (int c = 0; c < msm_pkg::CHANNELS; c++)
                  if (voice_id[c] == w.sound_id) begin
                     voice_id[c]   = 8'd0;
                     voice_reps[c] = 8'd0;
                  end
         end
         msm_pkg::REQ_STOP_ALL: begin
            for (int c = 0; c < msm_pkg::CHANNELS; c++)
               if (voice_id[c] != 8'd0) begin
                  voice_id[c]   = 8'd0;
                  voice_reps[c] = 8'd0;
               end
         end
         msm_pkg::REQ_WRITE: pcm_mem[w.address % msm_pkg::SAMPLE_MEM_DEPTH] = w.sample_byte;
         default: ;
      endcase
   endfunction

   // Cycles to wait before the next word on one side. Now and then a stretch
   // of back-to-back words is drawn instead.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // A word with every field random; callers overwrite the fields that matter.
   function automatic msm_pkg::req_word_type fuzz_word();
      msm_pkg::req_word_type w;
      w.req_type    = 3'($urandom);
      w.sound_id    = 8'($urandom);
      w.address     = 16'($urandom);
      w.length      = 16'($urandom);
      w.loop_count  = 8'($urandom);
      w.sample_byte = 8'($urandom);
      return w;
   endfunction

   function automatic msm_pkg::req_word_type req_word(logic [2:0] kind);
      msm_pkg::req_word_type w;
      w = fuzz_word();
      w.req_type = kind;
      return w;
   endfunction

   function automatic msm_pkg::req_word_type play_word(logic [7:0] id, logic [15:0] addr,
         logic [15:0] len, logic signed [7:0] reps);
      msm_pkg::req_word_type w;
      w = req_word(msm_pkg::REQ_PLAY);
      w.sound_id   = id;
      w.address    = addr;
      w.length     = len;
      w.loop_count = reps;
      return w;
   endfunction

   function automatic msm_pkg::req_word_type stop_word(logic [7:0] id);
      msm_pkg::req_word_type w;
      w = req_word(msm_pkg::REQ_STOP);
      w.sound_id = id;
      return w;
   endfunction

   function automatic msm_pkg::req_word_type byte_word(logic [15:0] addr, logic [7:0] value);
      msm_pkg::req_word_type w;
      w = req_word(msm_pkg::REQ_WRITE);
      w.address     = addr;
      w.sample_byte = value;
      return w;
   endfunction

   // Samples lean on the rails so that the sum clips often in both directions.
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // A small pool of sound ids makes rebinding and full channel sets common.
   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 6) == 0)
         return 8'($urandom_range(1, 255));
      return 8'($urandom_range(1, 7));
   endfunction

   function automatic logic signed [7:0] pick_reps();
      case ($urandom_range(0, 5))
         0:       return -8'sd1;
         1:       return 8'($urandom_range(128, 255));
         2:       return 8'sd1;
         3:       return 8'sd2;
         4:       return 8'($urandom_range(3, 127));
         default: return 8'($urandom_range(1, 3));
      endcase
   endfunction

   // One word of the random traffic while the mixer is enabled. Plays that
   // start a voice stay inside the written window; plays that bind an idle
   // voice or get dropped may carry any address and length, since they never
   // cause a memory read.
   function automatic msm_pkg::req_word_type random_word();
      msm_pkg::req_word_type w;
      int                    roll;
      int                    off;
      roll = $urandom_range(0, 99);
      off  = $urandom_range(0, WIN_SIZE - 1);
      w    = fuzz_word();
      if (roll < 38) begin
         w.req_type = msm_pkg::REQ_TICK;
      end else if (roll < 63) begin
         w = play_word(pick_id(), WIN_BASE + 16'(off),
                       16'($urandom_range(1, WIN_SIZE - off)), pick_reps());
      end else if (roll < 70) begin
         w.req_type   = msm_pkg::REQ_PLAY;
         w.sound_id   = pick_id();
         w.loop_count = 8'sd0;
      end else if (roll < 75) begin
         w.req_type = msm_pkg::REQ_PLAY;
         if ($urandom_range(0, 1) == 0)
            w.sound_id = 8'd0;
         else
            w.length = 16'd0;
      end else if (roll < 83) begin
         w = stop_word(($urandom_range(0, 5) == 0) ? 8'd0 : pick_id());
      end else if (roll < 86) begin
         w.req_type = msm_pkg::REQ_STOP_ALL;
      end else if (roll < 96) begin
         w = byte_word(($urandom_range(0, 2) != 0) ? WIN_BASE + 16'(off) : 16'($urandom),
                       pick_sample());
      end else begin
         w.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      end
      return w;
   endfunction

   // The enable bit is only written while nothing is in flight, so the
   // predictor may switch over at once.
   task automatic set_enable(input logic on);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      mix_on = on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every word has been taken and every mixed word has come
   // back, then gives the mixer time to finish a walk that owes no result.
   task automatic settle();
      while (word_backlog.size() > 0 || req_valid || mix_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Sender. A word is handed to the predictor at the edge where it is
   // accepted. The gap drawn when a word goes out is spent after that word
   // has been accepted, before the next one is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            mixer_advance(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (word_backlog.size() > 0) begin
               req_data  <= word_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = draw_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Every mixed word is checked against the oldest prediction.
   // Twice in the run it holds ready low for a long stretch while the sender
   // keeps going: the output register fills, the next tick stalls in its last
   // step, and the mixer has to stop taking request words.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mix_due.size() == 0) begin
               $display("%0t: mixed word with none expected: sample %0d active %0b",
                        $time, rsp_data.mixed_sample, rsp_data.any_active);
               bad_count++;
            end else begin
               mix_head = mix_due.pop_front();
               if (rsp_data.mixed_sample !== mix_head.mixed_sample) begin
                  $display("%0t: mixed_sample expected %0d actual %0d",
                           $time, mix_head.mixed_sample, rsp_data.mixed_sample);
                  bad_count++;
               end
               if (rsp_data.any_active !== mix_head.any_active) begin
                  $display("%0t: any_active expected %0b actual %0b",
                           $time, mix_head.any_active, rsp_data.any_active);
                  bad_count++;
               end
            end
            mix_taken++;
            if (mix_taken == 40 || mix_taken == 150)
               hold_off = 300;
            else
               take_gap = draw_wait(take_calm);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus in phases. The enable bit goes 0, 1, 0, 1; each change is made
   // only once the mixer has gone quiet.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Disabled: every word must vanish without a trace.
      set_enable(1'b0);
      repeat (8) word_backlog.push_back(fuzz_word());
      settle();
      set_enable(1'b1);

      // Load the sample window before anything can play from it.
      for (int a = 0; a < WIN_SIZE; a++)
         word_backlog.push_back(byte_word(WIN_BASE + 16'(a), pick_sample()));

      // Directed part. A tick with nothing playing, then sound id zero and
      // zero length, which are dropped.
      word_backlog.push_back(req_word(msm_pkg::REQ_TICK));
      word_backlog.push_back(play_word(8'd0, WIN_BASE, 16'd4, 8'sd1));
      word_backlog.push_back(play_word(8'd1, WIN_BASE, 16'd0, 8'sd1));
      word_backlog.push_back(req_word(msm_pkg::REQ_TICK));
      // Fill all five channels: a counted loop, a sound that wraps past the
      // top address with the most negative count, the largest positive count,
      // a forever loop, and a binding with count zero that leaves its channel
      // idle with an unwritten range that is never read.
      word_backlog.push_back(play_word(8'd1, WIN_BASE, 16'd3, 8'sd2));
      word_backlog.push_back(play_word(8'd2, 16'hFFFE, 16'd4, -8'sd128));
      word_backlog.push_back(play_word(8'd3, 16'h0000, 16'd1, 8'sd127));
      word_backlog.push_back(play_word(8'd4, WIN_BASE + 16'd8, 16'd5, -8'sd1));
      word_backlog.push_back(play_word(8'd5, 16'hABCD, 16'hFFFF, 8'sd0));
      // The idle channel is taken by a new sound; then the set is full and
      // another sound is dropped, while a playing sound is rebound in place.
      word_backlog.push_back(play_word(8'd6, 16'h0008, 16'd3, 8'sd3));
      word_backlog.push_back(play_word(8'd255, 16'h0000, 16'd2, 8'sd1));
      word_backlog.push_back(play_word(8'd2, 16'h0002, 16'd2, 8'sd1));
      repeat (5) word_backlog.push_back(req_word(msm_pkg::REQ_TICK));
      word_backlog.push_back(stop_word(8'd0));
      word_backlog.push_back(stop_word(8'd4));
      word_backlog.push_back(req_word(msm_pkg::REQ_TICK));
      word_backlog.push_back(req_word(REQ_UNUSED_FIRST));
      word_backlog.push_back(req_word(REQ_UNUSED_LAST));
      word_backlog.push_back(byte_word(16'h0001, 8'h00));
      word_backlog.push_back(req_word(msm_pkg::REQ_TICK));
      word_backlog.push_back(req_word(msm_pkg::REQ_STOP_ALL));
      word_backlog.push_back(req_word(msm_pkg::REQ_TICK));

      repeat (250) word_backlog.push_back(random_word());
      settle();

      // Disabled in mid-run: the voices must pick up where they left off.
      set_enable(1'b0);
      repeat (30) word_backlog.push_back(fuzz_word());
      settle();
      set_enable(1'b1);
      repeat (270) word_backlog.push_back(random_word());
      settle();

      if (bad_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #500000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
sv/msm_pkg.sv
sv/msm_ram.sv
sv/msm_ctrl.sv
sv/multichannel_sample_mixer.sv
tb/sv/tb_multichannel_sample_mixer.sv
